FILE: design/crs_pkg.sv
`default_nettype none
package crs_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int COORD_BITS  = 16;
   localparam int TARGET_BITS = 15;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int EMPTY_W     = 16;
   localparam int CSR_IDX_W   = 1;

   localparam logic [EMPTY_W-1:0] EMPTY_MAX = {EMPTY_W{1'b1}};
   localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(STACK_DEPTH);

   localparam logic [CSR_IDX_W-1:0] REG_TARGET_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_HEIGHT = 1'b1;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   typedef logic signed [COORD_BITS-1:0] crs_coord_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] left;
      logic signed [COORD_BITS-1:0] top;
      logic signed [COORD_BITS-1:0] right;
      logic signed [COORD_BITS-1:0] bottom;
   } crs_rect_type;

   typedef struct packed {
      crs_rect_type clip;
      logic         clip_present;
      logic         all_clipped;
      logic         overflow;
   } crs_result_type;

   typedef struct packed {
      logic load;
      logic exec;
   } crs_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SETTLE,
      ST_RESP
   } crs_state_type;

endpackage
`default_nettype wire

FILE: design/crs_if.sv
`default_nettype none
interface crs_req_if import crs_pkg::*; ();
   logic          valid;
   logic          ready;
   logic          mode;
   crs_coord_type rect_left;
   crs_coord_type rect_top;
   crs_coord_type rect_right;
   crs_coord_type rect_bottom;

   modport source (output valid, mode, rect_left, rect_top, rect_right, rect_bottom,
                   input ready);
   modport sink   (input valid, mode, rect_left, rect_top, rect_right, rect_bottom,
                   output ready);
endinterface

interface crs_rsp_if import crs_pkg::*; ();
   logic          valid;
   logic          ready;
   crs_coord_type clip_left;
   crs_coord_type clip_top;
   crs_coord_type clip_right;
   crs_coord_type clip_bottom;
   logic          clip_present;
   logic          all_clipped;
   logic          overflow;

   modport source (output valid, clip_left, clip_top, clip_right, clip_bottom,
                   clip_present, all_clipped, overflow,
                   input ready);
   modport sink   (input valid, clip_left, clip_top, clip_right, clip_bottom,
                   clip_present, all_clipped, overflow,
                   output ready);
endinterface
`default_nettype wire

FILE: design/crs_ctrl.sv
`default_nettype none
module crs_ctrl import crs_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output crs_cmd_type cmd
);

   crs_state_type state_ff;
   crs_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC:   state_in = ST_SETTLE;
         // wait for the registered read of the new top
         ST_SETTLE: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_EXEC:   cmd.exec = 1'b1;
         ST_SETTLE: ;
         ST_RESP:   rsp_valid = 1'b1;
         default:   ;
      endcase
   end

endmodule
`default_nettype wire

FILE: design/crs_dpath.sv
`default_nettype none
module crs_dpath import crs_pkg::*; (
   input  wire                    clock,
   input  wire                    reset,
   input  crs_cmd_type            cmd,
   input  wire                    csr_we,
   input  wire  [CSR_IDX_W-1:0]   csr_index,
   input  wire  [TARGET_BITS-1:0] csr_wdata,
   input  wire                    req_mode,
   input  crs_rect_type           req_rect,
   output crs_result_type         result
);

   logic [TARGET_BITS-1:0] width_ff;
   logic [TARGET_BITS-1:0] height_ff;
   logic                   mode_ff;
   crs_rect_type           rect_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [EMPTY_W-1:0]     empty_ff;
   logic [EMPTY_W-1:0]     empty_in;
   logic                   refused_ff;
   logic                   refused_in;
   crs_rect_type           top_ff;
   crs_rect_type           rect_mem [STACK_DEPTH];

   crs_rect_type     cur_clip;
   crs_rect_type     isect;
   logic             isect_ok;
   logic             mem_we;
   logic [CNT_W-1:0] count_m1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TARGET_WIDTH:  width_ff  <= csr_wdata;
            REG_TARGET_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         rect_ff <= req_rect;
      end
   end

   // whole target when nothing is stored
   always_comb begin
      if (count_ff == '0) begin
         cur_clip.left   = '0;
         cur_clip.top    = '0;
         cur_clip.right  = crs_coord_type'(width_ff);
         cur_clip.bottom = crs_coord_type'(height_ff);
      end else begin
         cur_clip = top_ff;
      end
   end

   always_comb begin
      isect.left   = (cur_clip.left   > rect_ff.left)   ? cur_clip.left   : rect_ff.left;
      isect.top    = (cur_clip.top    > rect_ff.top)    ? cur_clip.top    : rect_ff.top;
      isect.right  = (cur_clip.right  < rect_ff.right)  ? cur_clip.right  : rect_ff.right;
      isect.bottom = (cur_clip.bottom < rect_ff.bottom) ? cur_clip.bottom : rect_ff.bottom;
      isect_ok     = (isect.left < isect.right) && (isect.top < isect.bottom);
   end

   always_comb begin
      count_in   = count_ff;
      empty_in   = empty_ff;
      refused_in = refused_ff;
      mem_we     = 1'b0;
      if (cmd.exec) begin
         refused_in = 1'b0;
         if (mode_ff == MODE_PUSH) begin
            if (empty_ff != '0) begin
               if (empty_ff != EMPTY_MAX) empty_in = empty_ff + 1'b1;
            end else if (isect_ok) begin
               if (count_ff == CNT_FULL) begin
                  refused_in = 1'b1;
               end else begin
                  mem_we   = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end else begin
               empty_in = EMPTY_W'(1);
            end
         end else begin
            if (empty_ff != '0) begin
               empty_in = empty_ff - 1'b1;
            end else if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         empty_ff   <= '0;
         refused_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         empty_ff   <= empty_in;
         refused_ff <= refused_in;
      end
   end

   assign count_m1 = count_ff - 1'b1;

   // top entry is re-read every cycle; it settles in the cycle after the pointer moves
   always_ff @(posedge clock) begin
      if (mem_we) rect_mem[count_ff[ADDR_W-1:0]] <= isect;
      top_ff <= rect_mem[count_m1[ADDR_W-1:0]];
   end

   always_comb begin
      result.clip         = cur_clip;
      result.clip_present = (count_ff != '0);
      result.all_clipped  = (empty_ff != '0);
      result.overflow     = refused_ff;
   end

endmodule
`default_nettype wire

FILE: design/clip_rectangle_stack_top.sv
// Flow: an accepted item passes through the execute and settle states before its result
// is offered in the response state, where it is held until taken; no new item is taken
// until then. The settle state covers the registered read of the rectangle store after
// the stack pointer moves.
// Reset: synchronous, active high; clears the stack and fully-clipped counts, the
// target size and the controller. The rectangle store is not cleared.
`default_nettype none
module clip_rectangle_stack_top import crs_pkg::*; (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_we,
   input  wire  [CSR_IDX_W-1:0]   csr_index,
   input  wire  [TARGET_BITS-1:0] csr_wdata,
   crs_req_if.sink                req_if,
   crs_rsp_if.source              rsp_if
);

   crs_cmd_type    cmd;
   crs_rect_type   req_rect;
   crs_result_type result;

   assign req_rect.left   = req_if.rect_left;
   assign req_rect.top    = req_if.rect_top;
   assign req_rect.right  = req_if.rect_right;
   assign req_rect.bottom = req_if.rect_bottom;

   crs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   crs_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_mode  (req_if.mode),
      .req_rect  (req_rect),
      .result    (result)
   );

   assign rsp_if.clip_left    = result.clip.left;
   assign rsp_if.clip_top     = result.clip.top;
   assign rsp_if.clip_right   = result.clip.right;
   assign rsp_if.clip_bottom  = result.clip.bottom;
   assign rsp_if.clip_present = result.clip_present;
   assign rsp_if.all_clipped  = result.all_clipped;
   assign rsp_if.overflow     = result.overflow;

endmodule
`default_nettype wire

FILE: design/crs_checker.sv
`default_nettype none
module crs_checker (
   input wire clock,
   input wire reset,
   input wire req_valid,
   input wire req_ready,
   input wire rsp_valid,
   input wire rsp_ready,
   input wire clip_present,
   input wire all_clipped,
   input wire overflow
);

   // a held beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second beat taken while an item is in flight");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("input taken while a result is pending");

   // a refused push means a full stack and nothing clipped
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && overflow |-> clip_present && !all_clipped)
      else $error("overflow flagged without a full, unclipped stack");

endmodule

bind clip_rectangle_stack_top crs_checker u_crs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .clip_present (rsp_if.clip_present),
   .all_clipped  (rsp_if.all_clipped),
   .overflow     (rsp_if.overflow)
);
`default_nettype wire
